// ===== rtl/ksel_pkg.sv =====
// ----------------------------------------------------------------------------
// ksel_pkg
// Shared types and constants for the streaming kth-largest selector.
// ----------------------------------------------------------------------------
package ksel_pkg;

    localparam int DATA_W = 32;
    localparam int RANK_W = 5;

    // per-beat control broadcast to every cell
    typedef struct packed {
        logic                     load;
        logic signed [DATA_W-1:0] sample;
    } ksel_ctrl_t;

    // data handed from one cell to its right-hand neighbor
    typedef struct packed {
        logic                     gt;
        logic signed [DATA_W-1:0] value;
    } ksel_link_t;

endpackage

// ===== rtl/ksel_cell.sv =====
// ----------------------------------------------------------------------------
// ksel_cell
// One slot of the sorted keep list: holds a value, compares it with the
// incoming sample and takes the sample, its left neighbor's value or keeps its own.
// ----------------------------------------------------------------------------
module ksel_cell (
    input  logic                clk,
    input  ksel_pkg::ksel_ctrl_t ctrl,
    input  logic                slot_valid,
    input  ksel_pkg::ksel_link_t left,
    output ksel_pkg::ksel_link_t right,
    output logic signed [ksel_pkg::DATA_W-1:0] value_next
);
    import ksel_pkg::*;

    logic signed [DATA_W-1:0] value_reg;
    logic                     gt;

    // an empty slot ranks below any sample
    assign gt = !slot_valid || (ctrl.sample > value_reg);

    // shift right when the insert point is to the left, else take the sample if it ranks higher, else hold
    always_comb
    begin
        if (left.gt)
            value_next = left.value;
        else if (gt)
            value_next = ctrl.sample;
        else
            value_next = value_reg;
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
            value_reg <= value_next;
    end

    assign right.gt    = gt;
    assign right.value = value_reg;

endmodule

// ===== rtl/kth_largest_stream_select.sv =====
// ----------------------------------------------------------------------------
// kth_largest_stream_select
// Streaming top-k selector built as a chain of sorted keep cells.
// ----------------------------------------------------------------------------
// The block takes one sample beat per clock and keeps the largest k_rank
// values of the current set in a row of MAX_RANK cells, sorted largest
// first; every beat inserts in parallel across the cells, so the rate is one
// beat per cycle whenever the output register is free or being drained. The
// beat flagged tlast produces one result beat on the next cycle: the kth
// largest value in tdata and, in tuser, whether at least k values arrived
// (tdata is zero when not). The cell row needs no clearing after reset.
// k_rank of 0 acts as 1 and values above MAX_RANK act as MAX_RANK; a new
// rank written within a set applies from the next beat and never trims the
// values already held.
// ----------------------------------------------------------------------------
module kth_largest_stream_select #(
    parameter int MAX_RANK = 16
) (
    input  logic                        clk,
    input  logic                        rst_n,
    // configuration: k_rank
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [ksel_pkg::RANK_W-1:0] cfg_data,
    // input stream
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    input  logic [31:0]                 s_axis_tdata,   // [31:0] sample_value
    input  logic                        s_axis_tlast,   // last_of_set
    // result stream
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    output logic [31:0]                 m_axis_tdata,   // [31:0] kth_value
    output logic [0:0]                  m_axis_tuser    // [0] enough_items
);
    import ksel_pkg::*;

    localparam int CW = $clog2(MAX_RANK + 1);
    localparam int IW = (MAX_RANK > 1) ? $clog2(MAX_RANK) : 1;
    localparam int KW = (CW > RANK_W) ? CW : RANK_W;

    logic [RANK_W-1:0]        k_rank_reg;
    logic [CW-1:0]            count_reg;
    logic [CW-1:0]            count_next;
    logic [KW-1:0]            eff_rank;
    logic [CW-1:0]            count_after;
    logic [CW-1:0]            min_pos;
    logic [IW-1:0]            min_idx;
    logic                     enough;
    logic                     accept;
    logic                     out_valid_reg;
    logic signed [DATA_W-1:0] kth_reg;
    logic                     enough_reg;

    ksel_ctrl_t               ctrl;
    ksel_link_t               links [0:MAX_RANK];
    logic signed [DATA_W-1:0] cell_next [0:MAX_RANK-1];

    // configuration register
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            k_rank_reg <= RANK_W'(1);
        else if (cfg_valid && cfg_ready)
            k_rank_reg <= cfg_data;
    end

    // rank clamped to 1..MAX_RANK
    always_comb
    begin
        eff_rank = KW'(k_rank_reg);
        if (eff_rank == '0)
            eff_rank = KW'(1);
        else if (eff_rank > KW'(MAX_RANK))
            eff_rank = KW'(MAX_RANK);
    end

    // input handshake and cell control
    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign ctrl.load     = accept;
    assign ctrl.sample   = s_axis_tdata;

    // fill count grows until it reaches the rank
    assign count_after = (KW'(count_reg) < eff_rank) ? count_reg + CW'(1) : count_reg;
    assign count_next  = s_axis_tlast ? '0 : count_after;
    assign enough      = KW'(count_after) >= eff_rank;
    assign min_pos     = count_after - CW'(1);
    assign min_idx     = min_pos[IW-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= '0;
        else if (accept)
            count_reg <= count_next;
    end

    // cell chain
    assign links[0].gt    = 1'b0;
    assign links[0].value = '0;

    for (genvar i = 0; i < MAX_RANK; i++)
    begin : g_cell
        ksel_cell u_cell (
            .clk        (clk),
            .ctrl       (ctrl),
            .slot_valid (count_reg > CW'(i)),
            .left       (links[i]),
            .right      (links[i+1]),
            .value_next (cell_next[i])
        );
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (accept && s_axis_tlast)
            out_valid_reg <= 1'b1;
        else if (m_axis_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (accept && s_axis_tlast)
        begin
            kth_reg    <= enough ? cell_next[min_idx] : '0;
            enough_reg <= enough;
        end
    end

    assign m_axis_tvalid   = out_valid_reg;
    assign m_axis_tdata    = kth_reg;
    assign m_axis_tuser[0] = enough_reg;

endmodule

// ===== rtl/ksel_checker.sv =====
// ----------------------------------------------------------------------------
// ksel_checker
// Port-level checks for the kth-largest selector, bound to the top level.
// ----------------------------------------------------------------------------
module ksel_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        s_axis_tlast,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [31:0] m_axis_tdata,
    input logic [0:0]  m_axis_tuser
);

    // a stalled result beat stays offered
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result beat dropped while stalled");

    // a closing input beat yields a result beat next cycle
    a_last_result: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready && s_axis_tlast |=> m_axis_tvalid)
        else $error("no result after last beat of set");

    // a short set reports zero
    a_short_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata == 32'd0)
        else $error("short set result not zero");

    // input is open whenever the result slot is empty
    a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled with empty result slot");

endmodule

bind kth_largest_stream_select ksel_checker u_ksel_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
